>>> design/obr_pkg.sv
// Shared widths, defaults and codes for the offset bilinear remap block.
package obr_pkg;

	localparam int COORD_W = 16;
	localparam int LOAD_W = 7;
	localparam int SHIFT_W = 20;
	localparam int VALUE_W = 16;
	localparam int SIZE_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	// Wide enough for any clamped window size up to 1024.
	localparam int DIM_W = 11;
	localparam int FRACTION_BITS = 8;
	// Signed source position: 17-bit difference scaled by the fraction, less the shift.
	localparam int POS_W = COORD_W + FRACTION_BITS + 2;

	localparam int DEF_MAX_WINDOW_COLS = 128;
	localparam int DEF_MAX_WINDOW_ROWS = 128;
	localparam int DEF_PIXEL_BITS = 16;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_COLS     = 2'd2,
		REG_ROWS     = 2'd3
	} cfg_reg_t;

endpackage

>>> design/obr_if.sv
// Channel interfaces of the offset bilinear remap block: items in, results out, register writes.
interface obr_in_if import obr_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [LOAD_W-1:0]         load_col;
	logic [LOAD_W-1:0]         load_row;
	logic [VALUE_W-1:0]        pixel_value;
	logic [COORD_W-1:0]        out_col;
	logic [COORD_W-1:0]        out_row;
	logic signed [SHIFT_W-1:0] shift_x;
	logic signed [SHIFT_W-1:0] shift_y;
	logic                      shift_valid;

	modport source (
		output valid, opcode, load_col, load_row, pixel_value, out_col, out_row,
			shift_x, shift_y, shift_valid,
		input  ready
	);
	modport sink (
		input  valid, opcode, load_col, load_row, pixel_value, out_col, out_row,
			shift_x, shift_y, shift_valid,
		output ready
	);
endinterface

interface obr_out_if import obr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] sample_value;
	logic               sample_valid;

	modport source (output valid, sample_value, sample_valid, input ready);
	modport sink (input valid, sample_value, sample_valid, output ready);
endinterface

interface obr_cfg_if import obr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/obr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module obr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/offset_bilinear_remap_top.sv
// Top level of the offset bilinear remap block: window memory banks and sample pipeline.

// The block takes one transaction per cycle while the output side does not stall, loads and
// samples mixed freely; a sample passes source position, classify and address, bank read with
// horizontal blend, vertical blend and the output register. The source window is split into
// four banks by row and column parity, each with one write and one read port, so the four
// neighbours of a bilinear sample are read in the same cycle; that bank read sits in the third
// stage and sets the rate of one item per cycle. Loads write the banks in the same stage where
// samples read them, so every sample sees exactly the loads accepted before it. The window has
// no clearing pass: pixels read before they are loaded return unknown data. Configuration
// writes are taken at any time and should be made while the pipeline is empty.
module offset_bilinear_remap_top import obr_pkg::*; #(
	parameter int MAX_WINDOW_COLS = DEF_MAX_WINDOW_COLS,
	parameter int MAX_WINDOW_ROWS = DEF_MAX_WINDOW_ROWS,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	obr_in_if.sink    sample_in,
	obr_out_if.source sample_out,
	obr_cfg_if.sink   cfg
);

	localparam int XW = $clog2(MAX_WINDOW_COLS);
	localparam int YW = $clog2(MAX_WINDOW_ROWS);
	localparam int HALF_COLS = (MAX_WINDOW_COLS + 1) / 2;
	localparam int HALF_ROWS = (MAX_WINDOW_ROWS + 1) / 2;
	localparam int BANK_DEPTH = HALF_COLS * HALF_ROWS;
	localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int AMW = XW + YW + 1;
	localparam int IX_W = POS_W - FRACTION_BITS;
	localparam int WGT_W = FRACTION_BITS + 1;
	localparam int TOP_W = PIXEL_BITS + FRACTION_BITS;
	localparam int ACC_W = PIXEL_BITS + 2 * FRACTION_BITS;
	localparam int EXT_W = (PIXEL_BITS > VALUE_W) ? PIXEL_BITS : VALUE_W;

	localparam logic [WGT_W-1:0] W_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [POS_W-1:0] POS_HALF =
		{{(POS_W - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};
	localparam logic [ACC_W-1:0] ACC_HALF =
		{{PIXEL_BITS{1'b0}}, 1'b1, {(2 * FRACTION_BITS - 1){1'b0}}};
	localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_WINDOW_COLS);
	localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_WINDOW_ROWS);

	function automatic logic [BAW-1:0] bank_addr(input logic [YW-1:0] hr,
			input logic [XW-1:0] hc);
		return BAW'(AMW'(hr) * AMW'(HALF_COLS) + AMW'(hc));
	endfunction

	function automatic logic [DIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] w;
		w = DIM_W'(v);
		if (w == '0) begin
			return DIM_W'(1);
		end
		if (w > maxv) begin
			return maxv;
		end
		return w;
	endfunction

	// ---------------- configuration registers ----------------
	logic [COORD_W-1:0] origin_x_q;
	logic [COORD_W-1:0] origin_y_q;
	logic [SIZE_W-1:0]  cols_q;
	logic [SIZE_W-1:0]  rows_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			cols_q     <= SIZE_RESET;
			rows_q     <= SIZE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ORIGIN_X: origin_x_q <= COORD_W'(cfg.data);
				REG_ORIGIN_Y: origin_y_q <= COORD_W'(cfg.data);
				REG_COLS:     cols_q <= cfg.data[SIZE_W-1:0];
				REG_ROWS:     rows_q <= cfg.data[SIZE_W-1:0];
			endcase
		end
	end

	// ---------------- pipeline flow ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv1, adv2, adv3, adv4, adv5;

	// A stage advances when the next one is empty or advancing itself.
	assign adv5 = !v_s5 || sample_out.ready;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;

	assign sample_in.ready = adv1;

	logic load_s1, load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= sample_in.valid;
			if (adv2) v_s2 <= v_s1;
			// Loads retire once they write the banks.
			if (adv3) v_s3 <= v_s2 && !load_s2;
			if (adv4) v_s4 <= v_s3;
			if (adv5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: source position ----------------
	logic [POS_W-1:0] dx_c, dy_c, sx_c, sy_c;

	assign dx_c = POS_W'(sample_in.out_col) - POS_W'(origin_x_q);
	assign dy_c = POS_W'(sample_in.out_row) - POS_W'(origin_y_q);
	assign sx_c = (dx_c << FRACTION_BITS)
		- {{(POS_W - SHIFT_W){sample_in.shift_x[SHIFT_W-1]}}, sample_in.shift_x};
	assign sy_c = (dy_c << FRACTION_BITS)
		- {{(POS_W - SHIFT_W){sample_in.shift_y[SHIFT_W-1]}}, sample_in.shift_y};

	logic                  svalid_s1;
	logic [POS_W-1:0]      sx_s1, sy_s1;
	logic [XW-1:0]         lcol_s1;
	logic [YW-1:0]         lrow_s1;
	logic                  lin_s1;
	logic [PIXEL_BITS-1:0] lpix_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			load_s1   <= opcode_t'(sample_in.opcode) == OP_LOAD;
			svalid_s1 <= sample_in.shift_valid;
			sx_s1     <= sx_c;
			sy_s1     <= sy_c;
			lcol_s1   <= XW'(sample_in.load_col);
			lrow_s1   <= YW'(sample_in.load_row);
			lin_s1    <= (DIM_W'(sample_in.load_col) < MAX_COLS_D)
				&& (DIM_W'(sample_in.load_row) < MAX_ROWS_D);
			lpix_s1   <= PIXEL_BITS'(sample_in.pixel_value);
		end
	end

	// ---------------- stage 2: classify and address ----------------
	logic [DIM_W-1:0] cols_eff, rows_eff;
	logic [POS_W-1:0] lim_x, lim_y, nx_c, ny_c;
	logic [IX_W-1:0]  ix_c, iy_c;
	logic             inner_x, inner_y, in_x, in_y, inner_c, near_c;
	logic [XW-1:0]    cx_c, hc_even, hc_odd;
	logic [YW-1:0]    cy_c, hr_even, hr_odd;
	logic [XW:0]      cx_up;
	logic [YW:0]      cy_up;
	logic [BAW-1:0]   raddr_c [4];

	assign cols_eff = clamp_size(cols_q, MAX_COLS_D);
	assign rows_eff = clamp_size(rows_q, MAX_ROWS_D);
	assign lim_x = POS_W'(cols_eff - DIM_W'(1)) << FRACTION_BITS;
	assign lim_y = POS_W'(rows_eff - DIM_W'(1)) << FRACTION_BITS;

	assign inner_x = !sx_s1[POS_W-1] && (sx_s1 < lim_x);
	assign inner_y = !sy_s1[POS_W-1] && (sy_s1 < lim_y);

	// Nearest pixel: floor of position plus one half, taken from the high bits.
	assign nx_c = sx_s1 + POS_HALF;
	assign ny_c = sy_s1 + POS_HALF;
	assign ix_c = nx_c[POS_W-1:FRACTION_BITS];
	assign iy_c = ny_c[POS_W-1:FRACTION_BITS];
	assign in_x = !ix_c[IX_W-1] && (ix_c < IX_W'(cols_eff));
	assign in_y = !iy_c[IX_W-1] && (iy_c < IX_W'(rows_eff));

	assign inner_c = svalid_s1 && inner_x && inner_y;
	assign near_c  = svalid_s1 && !inner_c && in_x && in_y;

	assign cx_c = inner_c ? XW'(sx_s1[POS_W-1:FRACTION_BITS])
		: (near_c ? XW'(ix_c) : '0);
	assign cy_c = inner_c ? YW'(sy_s1[POS_W-1:FRACTION_BITS])
		: (near_c ? YW'(iy_c) : '0);

	// Even bank holds the even one of the pair (c, c+1); odd bank the odd one.
	assign cx_up   = {1'b0, cx_c} + {{XW{1'b0}}, inner_c};
	assign cy_up   = {1'b0, cy_c} + {{YW{1'b0}}, inner_c};
	assign hc_even = cx_up[XW:1];
	assign hr_even = cy_up[YW:1];
	assign hc_odd  = cx_c >> 1;
	assign hr_odd  = cy_c >> 1;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			raddr_c[b] = bank_addr(b[1] ? hr_odd : hr_even, b[0] ? hc_odd : hc_even);
		end
	end

	logic                      ok_s2, inner_s2, xpar_s2, ypar_s2;
	logic [FRACTION_BITS-1:0]  fx_s2, fy_s2;
	logic [BAW-1:0]            raddr_s2 [4];
	logic                      wen_s2;
	logic [1:0]                wbank_s2;
	logic [BAW-1:0]            waddr_s2;
	logic [PIXEL_BITS-1:0]     wdata_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			load_s2  <= load_s1;
			ok_s2    <= inner_c || near_c;
			inner_s2 <= inner_c;
			xpar_s2  <= cx_c[0];
			ypar_s2  <= cy_c[0];
			fx_s2    <= sx_s1[FRACTION_BITS-1:0];
			fy_s2    <= sy_s1[FRACTION_BITS-1:0];
			raddr_s2 <= raddr_c;
			wen_s2   <= lin_s1;
			wbank_s2 <= {lrow_s1[0], lcol_s1[0]};
			waddr_s2 <= bank_addr(lrow_s1 >> 1, lcol_s1 >> 1);
			wdata_s2 <= lpix_s1;
		end
	end

	// ---------------- window banks ----------------
	logic [PIXEL_BITS-1:0] bank_rd [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		obr_ram #(
			.WIDTH(PIXEL_BITS),
			.DEPTH(BANK_DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (adv3 && v_s2 && load_s2 && wen_s2 && (wbank_s2 == 2'(b))),
			.waddr(waddr_s2),
			.wdata(wdata_s2),
			.re   (adv3 && v_s2 && !load_s2),
			.raddr(raddr_s2[b]),
			.rdata(bank_rd[b])
		);
	end

	// ---------------- stage 3: horizontal blend ----------------
	logic                     ok_s3, inner_s3, xpar_s3, ypar_s3;
	logic [FRACTION_BITS-1:0] fx_s3, fy_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			ok_s3    <= ok_s2;
			inner_s3 <= inner_s2;
			xpar_s3  <= xpar_s2;
			ypar_s3  <= ypar_s2;
			fx_s3    <= fx_s2;
			fy_s3    <= fy_s2;
		end
	end

	logic [PIXEL_BITS-1:0] p00, p01, p10, p11;
	logic [WGT_W-1:0]      wx0, wx1;
	logic [TOP_W-1:0]      top_c, bot_c;

	assign p00 = bank_rd[{ypar_s3, xpar_s3}];
	assign p01 = bank_rd[{ypar_s3, !xpar_s3}];
	assign p10 = bank_rd[{!ypar_s3, xpar_s3}];
	assign p11 = bank_rd[{!ypar_s3, !xpar_s3}];
	assign wx1 = WGT_W'(fx_s3);
	assign wx0 = W_ONE - wx1;
	assign top_c = TOP_W'(p00) * TOP_W'(wx0) + TOP_W'(p01) * TOP_W'(wx1);
	assign bot_c = TOP_W'(p10) * TOP_W'(wx0) + TOP_W'(p11) * TOP_W'(wx1);

	// ---------------- stage 4: vertical blend and rounding ----------------
	logic                     ok_s4, inner_s4;
	logic [FRACTION_BITS-1:0] fy_s4;
	logic [TOP_W-1:0]         top_s4, bot_s4;
	logic [PIXEL_BITS-1:0]    pix_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			ok_s4    <= ok_s3;
			inner_s4 <= inner_s3;
			fy_s4    <= fy_s3;
			top_s4   <= top_c;
			bot_s4   <= bot_c;
			pix_s4   <= p00;
		end
	end

	logic [WGT_W-1:0]      wy0, wy1;
	logic [ACC_W-1:0]      acc_c;
	logic [PIXEL_BITS-1:0] pick_c;
	logic [EXT_W-1:0]      pick_w;
	logic [VALUE_W-1:0]    value_c;

	assign wy1 = WGT_W'(fy_s4);
	assign wy0 = W_ONE - wy1;
	assign acc_c = ACC_W'(top_s4) * ACC_W'(wy0) + ACC_W'(bot_s4) * ACC_W'(wy1) + ACC_HALF;
	assign pick_c = inner_s4 ? acc_c[ACC_W-1:2*FRACTION_BITS] : pix_s4;
	assign pick_w = EXT_W'(pick_c);
	assign value_c = ok_s4 ? pick_w[VALUE_W-1:0] : '0;

	// ---------------- stage 5: output register ----------------
	logic [VALUE_W-1:0] value_s5;
	logic               found_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			value_s5 <= value_c;
			found_s5 <= ok_s4;
		end
	end

	assign sample_out.valid        = v_s5;
	assign sample_out.sample_value = value_s5;
	assign sample_out.sample_valid = found_s5;

endmodule

>>> design/obr_checker.sv
// Port-level checks for the offset bilinear remap block, bound to its top level.
module obr_checker import obr_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] out_value,
	input logic               out_found
);

	// Hold a stalled result.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_found))
		else $error("stalled result changed");

	// Nodata results carry a zero value.
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_found |-> out_value == '0)
		else $error("nodata result with nonzero value");

	// A free output register must never block the input side.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked while output stage is free");

endmodule

bind offset_bilinear_remap_top obr_checker u_obr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (sample_in.ready),
	.out_valid(sample_out.valid),
	.out_ready(sample_out.ready),
	.out_value(sample_out.sample_value),
	.out_found(sample_out.sample_valid)
);
